// File: rtl/jgkf_pkg.sv
// Package: types, constants and microcode table of the jump-gated force filter.
`timescale 1ns / 1ps

package jgkf_pkg;

	// Block shape
	localparam int AXES      = 3;
	localparam int FRAC_BITS = 16;
	localparam int DATA_W    = 32;

	// Configuration register widths
	localparam int Q_W       = 17;
	localparam int R_W       = 23;
	localparam int THR_W     = 31;
	localparam int BLEND_W   = 17;
	localparam int CFG_W     = 31;
	localparam int CFG_IDX_W = 2;

	// Reset values of the registers (Q16.16 codes)
	localparam logic [Q_W-1:0]     PROCESS_NOISE_RST     = Q_W'(66);
	localparam logic [R_W-1:0]     MEASUREMENT_NOISE_RST = R_W'(6554);
	localparam logic [THR_W-1:0]   JUMP_THRESHOLD_RST    = THR_W'(3932160);
	localparam logic [BLEND_W-1:0] BLEND_WEIGHT_RST      = BLEND_W'(25035);

	// Datapath widths
	localparam int GAIN_W  = FRAC_BITS + 1;           // gain in [0, ONE]
	localparam int PP_W    = DATA_W + 1;              // P + Q
	localparam int DEN_W   = DATA_W + 2;              // P + Q + R
	localparam int DIFF_W  = DATA_W + 1;              // sample minus estimate
	localparam int MUL_A_W = DATA_W + 2;
	localparam int MUL_B_W = GAIN_W + 1;
	localparam int PROD_W  = MUL_A_W + MUL_B_W;
	localparam int PRED_W  = DATA_W + 4;              // prediction and sums before clamp
	localparam int DIV_CNT_W = $clog2(FRAC_BITS);
	localparam int AXIS_W  = (AXES > 1) ? $clog2(AXES) : 1;

	// Register indexes
	typedef enum logic [CFG_IDX_W-1:0] {
		REG_PROCESS_NOISE     = 2'd0,
		REG_MEASUREMENT_NOISE = 2'd1,
		REG_JUMP_THRESHOLD    = 2'd2,
		REG_BLEND_WEIGHT      = 2'd3
	} cfg_reg_t;

	// Request payloads
	typedef struct packed {
		logic signed [DATA_W-1:0] force_x;
		logic signed [DATA_W-1:0] force_y;
		logic signed [DATA_W-1:0] force_z;
	} sample_t;

	typedef struct packed {
		logic signed [DATA_W-1:0] filtered_x;
		logic signed [DATA_W-1:0] filtered_y;
		logic signed [DATA_W-1:0] filtered_z;
		logic signed [DATA_W-1:0] delta_x;
		logic signed [DATA_W-1:0] delta_y;
		logic signed [DATA_W-1:0] delta_z;
	} result_t;

	// Datapath micro-operations
	typedef enum logic [3:0] {
		OP_NOP,
		OP_PREP,      // P+Q and P+Q+R
		OP_DIV_INT,   // integer quotient bit of the gain
		OP_DIV_STEP,  // one fraction bit of the gain
		OP_CLAMP,     // limit gain to one
		OP_MUL_COV,   // (ONE-K)*Pp
		OP_COV_WB,    // store new covariance, start axis loop
		OP_DIFF,      // z - x
		OP_MUL_Z,     // z*w, jump test
		OP_MUL_X,     // x*(ONE-w)
		OP_BLEND,     // rounded blend or old estimate
		OP_MUL_G,     // K*(z-x)
		OP_ROUND,     // round the innovation term
		OP_EST,       // new saturated estimate
		OP_STORE,     // write estimate and delta, next axis
		OP_OUT        // load the output register
	} uop_t;

	// Jump conditions
	typedef enum logic [2:0] {
		C_NEXT,
		C_ALWAYS,
		C_NO_REQ,
		C_DIV_LOOP,
		C_AXIS_LOOP,
		C_OUT_BUSY
	} cond_t;

	localparam int STEP_W = 5;
	typedef logic [STEP_W-1:0] step_t;

	localparam step_t STEP_IDLE     = 5'd0;
	localparam step_t STEP_PREP     = 5'd1;
	localparam step_t STEP_DIV_INT  = 5'd2;
	localparam step_t STEP_DIV      = 5'd3;
	localparam step_t STEP_CLAMP    = 5'd4;
	localparam step_t STEP_MUL_COV  = 5'd5;
	localparam step_t STEP_COV_WB   = 5'd6;
	localparam step_t STEP_AXIS     = 5'd7;
	localparam step_t STEP_MUL_Z    = 5'd8;
	localparam step_t STEP_MUL_X    = 5'd9;
	localparam step_t STEP_BLEND    = 5'd10;
	localparam step_t STEP_MUL_G    = 5'd11;
	localparam step_t STEP_ROUND    = 5'd12;
	localparam step_t STEP_EST      = 5'd13;
	localparam step_t STEP_STORE    = 5'd14;
	localparam step_t STEP_OUT_WAIT = 5'd15;
	localparam step_t STEP_OUT      = 5'd16;

	// One control word per step
	typedef struct packed {
		uop_t  op;
		cond_t cond;
		step_t target;
	} ctrl_t;

	// Microcode ROM: jump to target when the condition holds, else fall through
	function automatic ctrl_t ucode(input step_t step);
		ctrl_t cw;
		cw = '{op: OP_NOP, cond: C_ALWAYS, target: STEP_IDLE};
		unique case (step)
			STEP_IDLE:     cw = '{op: OP_NOP,       cond: C_NO_REQ,    target: STEP_IDLE};
			STEP_PREP:     cw = '{op: OP_PREP,      cond: C_NEXT,      target: STEP_IDLE};
			STEP_DIV_INT:  cw = '{op: OP_DIV_INT,   cond: C_NEXT,      target: STEP_IDLE};
			STEP_DIV:      cw = '{op: OP_DIV_STEP,  cond: C_DIV_LOOP,  target: STEP_DIV};
			STEP_CLAMP:    cw = '{op: OP_CLAMP,     cond: C_NEXT,      target: STEP_IDLE};
			STEP_MUL_COV:  cw = '{op: OP_MUL_COV,   cond: C_NEXT,      target: STEP_IDLE};
			STEP_COV_WB:   cw = '{op: OP_COV_WB,    cond: C_NEXT,      target: STEP_IDLE};
			STEP_AXIS:     cw = '{op: OP_DIFF,      cond: C_NEXT,      target: STEP_IDLE};
			STEP_MUL_Z:    cw = '{op: OP_MUL_Z,     cond: C_NEXT,      target: STEP_IDLE};
			STEP_MUL_X:    cw = '{op: OP_MUL_X,     cond: C_NEXT,      target: STEP_IDLE};
			STEP_BLEND:    cw = '{op: OP_BLEND,     cond: C_NEXT,      target: STEP_IDLE};
			STEP_MUL_G:    cw = '{op: OP_MUL_G,     cond: C_NEXT,      target: STEP_IDLE};
			STEP_ROUND:    cw = '{op: OP_ROUND,     cond: C_NEXT,      target: STEP_IDLE};
			STEP_EST:      cw = '{op: OP_EST,       cond: C_NEXT,      target: STEP_IDLE};
			STEP_STORE:    cw = '{op: OP_STORE,     cond: C_AXIS_LOOP, target: STEP_AXIS};
			STEP_OUT_WAIT: cw = '{op: OP_NOP,       cond: C_OUT_BUSY,  target: STEP_OUT_WAIT};
			STEP_OUT:      cw = '{op: OP_OUT,       cond: C_ALWAYS,    target: STEP_IDLE};
			default:       cw = '{op: OP_NOP,       cond: C_ALWAYS,    target: STEP_IDLE};
		endcase
		return cw;
	endfunction

	// Clamp to the signed 32-bit range
	function automatic logic signed [DATA_W-1:0] sat32(input logic signed [PRED_W-1:0] v);
		logic signed [PRED_W-1:0] hi;
		logic signed [PRED_W-1:0] lo;
		hi = PRED_W'({1'b0, {(DATA_W-1){1'b1}}});
		lo = -hi - PRED_W'(1);
		if (v > hi)
			return {1'b0, {(DATA_W-1){1'b1}}};
		else if (v < lo)
			return {1'b1, {(DATA_W-1){1'b0}}};
		else
			return v[DATA_W-1:0];
	endfunction

endpackage

// File: rtl/jump_gated_kalman_force_filter.sv
// Top level: jump-gated scalar Kalman filter over three force axes, microcoded datapath.
// A new sample is taken only in the idle step, so one sample is in flight at a time; the pace is
// set by the bit-serial gain divider and the single shared multiplier stepped per axis, and the
// sequencer waits before loading the output while an earlier result has not been taken.
// Reset: estimates clear to zero, covariance to one, registers to their defaults.
`timescale 1ns / 1ps

module jump_gated_kalman_force_filter (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              sample_valid,
	output logic                              sample_ready,
	input  jgkf_pkg::sample_t                 sample,
	output logic                              result_valid,
	input  logic                              result_ready,
	output jgkf_pkg::result_t                 result,
	input  logic                              cfg_we,
	input  logic [jgkf_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [jgkf_pkg::CFG_W-1:0]        cfg_data
);

	localparam int F       = jgkf_pkg::FRAC_BITS;
	localparam int AXES    = jgkf_pkg::AXES;
	localparam int DATA_W  = jgkf_pkg::DATA_W;
	localparam int GAIN_W  = jgkf_pkg::GAIN_W;
	localparam int PP_W    = jgkf_pkg::PP_W;
	localparam int DEN_W   = jgkf_pkg::DEN_W;
	localparam int DIFF_W  = jgkf_pkg::DIFF_W;
	localparam int MUL_A_W = jgkf_pkg::MUL_A_W;
	localparam int MUL_B_W = jgkf_pkg::MUL_B_W;
	localparam int PROD_W  = jgkf_pkg::PROD_W;
	localparam int PRED_W  = jgkf_pkg::PRED_W;
	localparam int CNT_W   = jgkf_pkg::DIV_CNT_W;
	localparam int AXIS_W  = jgkf_pkg::AXIS_W;

	localparam logic [GAIN_W-1:0] GAIN_ONE = {1'b1, {F{1'b0}}};
	localparam logic signed [PROD_W:0] ROUND_HALF =
		{{(PROD_W+1-F){1'b0}}, 1'b1, {(F-1){1'b0}}};
	localparam logic [CNT_W-1:0]  DIV_LAST  = CNT_W'(F - 1);
	localparam logic [AXIS_W-1:0] AXIS_LAST = AXIS_W'(AXES - 1);

	// Sequencer
	jgkf_pkg::step_t pc_q, pc_next;
	jgkf_pkg::ctrl_t cw;
	logic            jump;
	logic            in_fire;
	logic            out_fire;

	// Configuration registers
	logic [jgkf_pkg::Q_W-1:0]     q_noise_q;
	logic [jgkf_pkg::R_W-1:0]     r_noise_q;
	logic [jgkf_pkg::THR_W-1:0]   thr_q;
	logic [jgkf_pkg::BLEND_W-1:0] blend_q;

	// Filter state
	logic signed [DATA_W-1:0] est_mem_q [AXES];
	logic        [DATA_W-1:0] cov_q;

	// Datapath registers
	logic signed [DATA_W-1:0] z_q      [AXES];
	logic signed [DATA_W-1:0] res_f_q  [AXES];
	logic signed [DATA_W-1:0] res_d_q  [AXES];
	logic        [PP_W-1:0]   pp_q;
	logic        [DEN_W-1:0]  den_q;
	logic        [DEN_W-1:0]  rem_q;
	logic        [GAIN_W-1:0] gain_q;
	logic        [CNT_W-1:0]  div_cnt_q;
	logic        [AXIS_W-1:0] axis_q;
	logic signed [DIFF_W-1:0] diff_q;
	logic                     jump_q;
	logic signed [PROD_W-1:0] mul_q;
	logic signed [PROD_W-1:0] acc_q;
	logic signed [PRED_W-1:0] pred_q;
	logic signed [PRED_W-1:0] rnd_q;
	logic signed [DATA_W-1:0] est_q;
	logic                     result_valid_q;
	jgkf_pkg::result_t        result_q;

	// Combinational datapath
	logic signed [DATA_W-1:0]  z_sel;
	logic signed [DATA_W-1:0]  x_sel;
	logic signed [MUL_A_W-1:0] mul_a;
	logic signed [MUL_B_W-1:0] mul_b;
	logic                      is_mul;
	logic                      int_ge;
	logic        [DEN_W:0]     rem2;
	logic                      step_ge;
	logic        [DIFF_W-1:0]  mag;
	logic signed [PROD_W:0]    blend_sum;
	logic signed [PROD_W:0]    rnd_sum;
	logic signed [PRED_W-1:0]  est_sum;
	logic signed [PRED_W-1:0]  delta_sum;

	assign in_fire      = sample_valid & sample_ready;
	assign out_fire     = result_valid_q & result_ready;
	assign sample_ready = (pc_q == jgkf_pkg::STEP_IDLE);
	assign result_valid = result_valid_q;
	assign result       = result_q;

	// Microcode fetch and jump decision
	assign cw = jgkf_pkg::ucode(pc_q);

	always_comb begin
		unique case (cw.cond)
			jgkf_pkg::C_NEXT:      jump = 1'b0;
			jgkf_pkg::C_ALWAYS:    jump = 1'b1;
			jgkf_pkg::C_NO_REQ:    jump = ~in_fire;
			jgkf_pkg::C_DIV_LOOP:  jump = (div_cnt_q != DIV_LAST);
			jgkf_pkg::C_AXIS_LOOP: jump = (axis_q != AXIS_LAST);
			jgkf_pkg::C_OUT_BUSY:  jump = result_valid_q & ~result_ready;
			default:               jump = 1'b1;
		endcase
	end

	always_comb begin
		if (jump)
			pc_next = cw.target;
		else
			pc_next = pc_q + jgkf_pkg::step_t'(1);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			pc_q <= jgkf_pkg::STEP_IDLE;
		else
			pc_q <= pc_next;
	end

	// Configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			q_noise_q <= jgkf_pkg::PROCESS_NOISE_RST;
			r_noise_q <= jgkf_pkg::MEASUREMENT_NOISE_RST;
			thr_q     <= jgkf_pkg::JUMP_THRESHOLD_RST;
			blend_q   <= jgkf_pkg::BLEND_WEIGHT_RST;
		end else if (cfg_we) begin
			unique case (jgkf_pkg::cfg_reg_t'(cfg_index))
				jgkf_pkg::REG_PROCESS_NOISE:     q_noise_q <= cfg_data[jgkf_pkg::Q_W-1:0];
				jgkf_pkg::REG_MEASUREMENT_NOISE: r_noise_q <= cfg_data[jgkf_pkg::R_W-1:0];
				jgkf_pkg::REG_JUMP_THRESHOLD:    thr_q     <= cfg_data[jgkf_pkg::THR_W-1:0];
				jgkf_pkg::REG_BLEND_WEIGHT:      blend_q   <= cfg_data[jgkf_pkg::BLEND_W-1:0];
				default: ;
			endcase
		end
	end

	// Per-axis operand select
	assign z_sel = z_q[axis_q];
	assign x_sel = est_mem_q[axis_q];

	// Shared multiplier operands
	always_comb begin
		mul_a  = '0;
		mul_b  = '0;
		is_mul = 1'b0;
		unique case (cw.op)
			jgkf_pkg::OP_MUL_COV: begin
				mul_a  = $signed({1'b0, pp_q});
				mul_b  = $signed({1'b0, GAIN_ONE - gain_q});
				is_mul = 1'b1;
			end
			jgkf_pkg::OP_MUL_Z: begin
				mul_a  = MUL_A_W'(z_sel);
				mul_b  = $signed({1'b0, blend_q});
				is_mul = 1'b1;
			end
			jgkf_pkg::OP_MUL_X: begin
				mul_a  = MUL_A_W'(x_sel);
				mul_b  = $signed({1'b0, GAIN_ONE}) - $signed({1'b0, blend_q});
				is_mul = 1'b1;
			end
			jgkf_pkg::OP_MUL_G: begin
				mul_a  = MUL_A_W'(diff_q);
				mul_b  = $signed({1'b0, gain_q});
				is_mul = 1'b1;
			end
			default: ;
		endcase
	end

	// Divider compares, jump test and rounding sums
	assign int_ge    = ({1'b0, pp_q} >= den_q);
	assign rem2      = {rem_q, 1'b0};
	assign step_ge   = (rem2 >= {1'b0, den_q});
	assign mag       = diff_q[DIFF_W-1] ? DIFF_W'(-diff_q) : DIFF_W'(diff_q);
	assign blend_sum = (PROD_W+1)'(acc_q) + (PROD_W+1)'(mul_q) + ROUND_HALF;
	assign rnd_sum   = (PROD_W+1)'(mul_q) + ROUND_HALF;
	assign est_sum   = pred_q + rnd_q;
	assign delta_sum = PRED_W'(est_q) - PRED_W'(x_sel);

	// Filter state: shared covariance and per-axis estimates
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cov_q <= DATA_W'(GAIN_ONE);
			for (int i = 0; i < AXES; i++)
				est_mem_q[i] <= '0;
		end else begin
			if (cw.op == jgkf_pkg::OP_COV_WB) begin
				if (|mul_q[PROD_W-1:F+DATA_W])
					cov_q <= '1;
				else
					cov_q <= mul_q[F+DATA_W-1:F];
			end
			if (cw.op == jgkf_pkg::OP_STORE)
				est_mem_q[axis_q] <= est_q;
		end
	end

	// Loop counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			div_cnt_q <= '0;
			axis_q    <= '0;
		end else begin
			if (cw.op == jgkf_pkg::OP_DIV_INT)
				div_cnt_q <= '0;
			else if (cw.op == jgkf_pkg::OP_DIV_STEP)
				div_cnt_q <= div_cnt_q + CNT_W'(1);
			if (cw.op == jgkf_pkg::OP_COV_WB)
				axis_q <= '0;
			else if (cw.op == jgkf_pkg::OP_STORE && axis_q != AXIS_LAST)
				axis_q <= axis_q + AXIS_W'(1);
		end
	end

	// Output register handshake
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			result_valid_q <= 1'b0;
		else if (cw.op == jgkf_pkg::OP_OUT)
			result_valid_q <= 1'b1;
		else if (out_fire)
			result_valid_q <= 1'b0;
	end

	// Datapath payload registers
	always_ff @(posedge clk) begin
		if (in_fire) begin
			z_q[0] <= sample.force_x;
			z_q[1] <= sample.force_y;
			z_q[2] <= sample.force_z;
		end
		if (is_mul)
			mul_q <= mul_a * mul_b;
		unique case (cw.op)
			jgkf_pkg::OP_PREP: begin
				pp_q  <= PP_W'(cov_q) + PP_W'(q_noise_q);
				den_q <= DEN_W'(cov_q) + DEN_W'(q_noise_q) + DEN_W'(r_noise_q);
			end
			jgkf_pkg::OP_DIV_INT: begin
				rem_q  <= int_ge ? DEN_W'({1'b0, pp_q} - den_q) : DEN_W'(pp_q);
				gain_q <= GAIN_W'(int_ge);
			end
			jgkf_pkg::OP_DIV_STEP: begin
				rem_q  <= step_ge ? DEN_W'(rem2 - {1'b0, den_q}) : rem2[DEN_W-1:0];
				gain_q <= {gain_q[GAIN_W-2:0], step_ge};
			end
			jgkf_pkg::OP_CLAMP: begin
				// zero denominator leaves an all-ones quotient
				if (gain_q > GAIN_ONE)
					gain_q <= GAIN_ONE;
			end
			jgkf_pkg::OP_DIFF: begin
				diff_q <= DIFF_W'(z_sel) - DIFF_W'(x_sel);
			end
			jgkf_pkg::OP_MUL_Z: begin
				jump_q <= (mag >= DIFF_W'(thr_q));
			end
			jgkf_pkg::OP_MUL_X: begin
				acc_q <= mul_q;
			end
			jgkf_pkg::OP_BLEND: begin
				if (jump_q)
					pred_q <= $signed(blend_sum[F+PRED_W-1:F]);
				else
					pred_q <= PRED_W'(x_sel);
			end
			jgkf_pkg::OP_ROUND: begin
				rnd_q <= $signed(rnd_sum[F+PRED_W-1:F]);
			end
			jgkf_pkg::OP_EST: begin
				est_q <= jgkf_pkg::sat32(est_sum);
			end
			jgkf_pkg::OP_STORE: begin
				res_f_q[axis_q] <= est_q;
				res_d_q[axis_q] <= jgkf_pkg::sat32(delta_sum);
			end
			jgkf_pkg::OP_OUT: begin
				result_q.filtered_x <= res_f_q[0];
				result_q.filtered_y <= res_f_q[1];
				result_q.filtered_z <= res_f_q[2];
				result_q.delta_x    <= res_d_q[0];
				result_q.delta_y    <= res_d_q[1];
				result_q.delta_z    <= res_d_q[2];
			end
			default: ;
		endcase
	end

endmodule
